// ===== src/clnw_pkg.sv =====
// Shared types and constants for the CLNW exponent recoder.
package clnw_pkg;

	localparam int unsigned WORD_BITS_DEF = 32;
	localparam int unsigned MAX_WORDS_DEF = 128;
	localparam int unsigned RESULT_LIMIT  = 16;
	localparam int unsigned CFG_W         = 8;
	localparam int unsigned VAL_W         = 7;
	localparam int unsigned LEN_W         = 13;
	localparam int unsigned FILL_W        = 3;
	localparam logic [CFG_W-1:0] WORDS_RESET = 8'd32;

	// Bit-count thresholds that select the window width.
	localparam int unsigned THRESH_W5 = 256;
	localparam int unsigned THRESH_W6 = 768;
	localparam int unsigned THRESH_W7 = 1792;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_FLUSH,
		OP_BIT,
		OP_CLOSE,
		OP_FINAL
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic two_emit;
		logic bit_emits;
		logic close_emits;
		logic last_bit;
		logic at_end;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== src/clnw_ctrl.sv =====
// Sequencing controller for the CLNW exponent recoder.
module clnw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  clnw_pkg::dp_sts_t sts,
	output clnw_pkg::dp_cmd_t cmd
);
	import clnw_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_CLOSE,
		S_FINAL
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				// A one bit after a zero run with a held window yields two requests;
				// the held window goes out first on its own cycle.
				if (sts.two_emit) begin
					if (sts.out_free) begin
						cmd.op = OP_FLUSH;
					end
				end else if (!sts.bit_emits || sts.out_free) begin
					cmd.op = OP_BIT;
					if (sts.last_bit) begin
						state_d = S_CLOSE;
					end
				end
			end
			S_CLOSE: begin
				if (!sts.at_end) begin
					state_d = S_IDLE;
				end else if (!sts.close_emits || sts.out_free) begin
					cmd.op  = OP_CLOSE;
					state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				if (sts.out_free) begin
					cmd.op  = OP_FINAL;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_LOAD) |-> (state_q == S_IDLE && in_valid))
		else $error("word loaded outside idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINAL && sts.out_free) |=> (state_q == S_IDLE))
		else $error("final request did not return to idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FLUSH) |-> sts.out_free)
		else $error("flush issued with output register busy");

endmodule

// ===== src/clnw_dp.sv =====
// Bit-serial scan datapath and output register of the CLNW exponent recoder.
module clnw_dp #(
	parameter int unsigned WORD_BITS = clnw_pkg::WORD_BITS_DEF,
	parameter int unsigned MAX_WORDS = clnw_pkg::MAX_WORDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [clnw_pkg::CFG_W-1:0]  cfg_data,
	input  logic [WORD_BITS-1:0]        exponent_word,
	input  clnw_pkg::dp_cmd_t           cmd,
	output clnw_pkg::dp_sts_t           sts,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic [clnw_pkg::VAL_W-1:0]  window_value,
	output logic [clnw_pkg::LEN_W-1:0]  window_length,
	output logic                        has_window,
	output logic [clnw_pkg::VAL_W-1:0]  largest_window,
	output logic [clnw_pkg::LEN_W-1:0]  window_count,
	output logic                        final_result
);
	import clnw_pkg::*;

	localparam int unsigned POS_W  = $clog2(MAX_WORDS * WORD_BITS + 1);
	localparam int unsigned K_W    = $clog2(WORD_BITS);
	localparam int unsigned WCNT_W = $clog2(RESULT_LIMIT + 1);

	logic [CFG_W-1:0]     words_q;
	logic [WORD_BITS-1:0] word_q;
	logic [K_W-1:0]       k_q;
	logic [POS_W-1:0]     pos_q;
	logic                 phase_q;
	logic [POS_W-1:0]     zrl_q;
	logic [VAL_W-1:0]     acc_q;
	logic [FILL_W-1:0]    fill_q;
	logic [VAL_W-1:0]     held_val_q;
	logic [FILL_W-1:0]    held_len_q;
	logic                 held_valid_q;
	logic [VAL_W-1:0]     largest_q;
	logic [LEN_W-1:0]     frags_q;
	logic [WCNT_W-1:0]    wres_q;

	logic [8:0]        words_eff;
	logic [POS_W-1:0]  nbits;
	logic [FILL_W-1:0] win_d;
	logic              bit_in;
	logic [VAL_W-1:0]  acc_n;
	logic [FILL_W-1:0] fill_n;
	logic              win_full;
	logic [POS_W:0]    final_len;
	logic              out_free;

	logic              emit;
	logic [VAL_W-1:0]  e_val;
	logic [LEN_W-1:0]  e_len;
	logic              e_has;
	logic [VAL_W-1:0]  e_large;
	logic [LEN_W-1:0]  e_cnt;
	logic              e_fin;
	logic              load_out;

	// Word count is clamped to 1..MAX_WORDS before it sets the bit count.
	always_comb begin
		if (words_q == '0) begin
			words_eff = 9'd1;
		end else if (9'(words_q) > 9'(MAX_WORDS)) begin
			words_eff = 9'(MAX_WORDS);
		end else begin
			words_eff = 9'(words_q);
		end
		nbits = POS_W'(words_eff * WORD_BITS);
		if (32'(nbits) < THRESH_W5) begin
			win_d = 3'd4;
		end else if (32'(nbits) < THRESH_W6) begin
			win_d = 3'd5;
		end else if (32'(nbits) < THRESH_W7) begin
			win_d = 3'd6;
		end else begin
			win_d = 3'd7;
		end
	end

	assign bit_in    = word_q[k_q];
	assign acc_n     = acc_q | (VAL_W'(bit_in) << fill_q);
	assign fill_n    = fill_q + 3'd1;
	assign win_full  = (fill_n >= win_d);
	assign final_len = (POS_W+1)'(held_len_q) + (POS_W+1)'(zrl_q);
	assign out_free  = !out_valid || !out_stall;

	always_comb begin
		sts.two_emit    = !phase_q && bit_in && (zrl_q != '0) && held_valid_q;
		sts.bit_emits   = (phase_q && win_full && held_valid_q) ||
		                  (!phase_q && bit_in && (zrl_q != '0));
		sts.close_emits = phase_q && held_valid_q;
		sts.last_bit    = (k_q == K_W'(WORD_BITS - 1));
		sts.at_end      = (pos_q >= nbits);
		sts.out_free    = out_free;
	end

	// Which request, if any, the current command produces.
	always_comb begin
		emit    = 1'b0;
		e_val   = held_val_q;
		e_len   = LEN_W'(held_len_q);
		e_has   = 1'b1;
		e_large = '0;
		e_cnt   = '0;
		e_fin   = 1'b0;
		case (cmd.op)
			OP_FLUSH: begin
				emit = held_valid_q;
			end
			OP_BIT: begin
				if (phase_q) begin
					emit = win_full && held_valid_q;
				end else if (bit_in && (zrl_q != '0)) begin
					emit  = 1'b1;
					e_val = '0;
					e_len = LEN_W'(zrl_q);
				end
			end
			OP_CLOSE: begin
				emit = phase_q && held_valid_q;
			end
			OP_FINAL: begin
				emit  = 1'b1;
				e_fin = 1'b1;
				if (held_valid_q) begin
					e_len   = LEN_W'(final_len);
					e_large = largest_q;
					e_cnt   = frags_q + 13'd1;
				end else begin
					e_val = '0;
					e_len = '0;
					e_has = 1'b0;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Requests past the per-word limit are dropped but still counted.
	assign load_out = emit && (wres_q < WCNT_W'(RESULT_LIMIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q      <= WORDS_RESET;
			k_q          <= '0;
			pos_q        <= '0;
			phase_q      <= 1'b0;
			zrl_q        <= '0;
			acc_q        <= '0;
			fill_q       <= '0;
			held_val_q   <= '0;
			held_len_q   <= '0;
			held_valid_q <= 1'b0;
			largest_q    <= '0;
			frags_q      <= '0;
			wres_q       <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (cfg_we) begin
				words_q <= cfg_data;
			end
			if (load_out) begin
				out_valid <= 1'b1;
				wres_q    <= wres_q + WCNT_W'(1);
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (emit && cmd.op != OP_FINAL) begin
				frags_q <= frags_q + 13'd1;
			end
			case (cmd.op)
				OP_LOAD: begin
					k_q    <= '0;
					wres_q <= '0;
				end
				OP_FLUSH: begin
					held_valid_q <= 1'b0;
				end
				OP_BIT: begin
					k_q   <= k_q + K_W'(1);
					pos_q <= pos_q + POS_W'(1);
					if (phase_q) begin
						if (win_full) begin
							held_val_q   <= acc_n;
							held_len_q   <= fill_n;
							held_valid_q <= 1'b1;
							if (acc_n > largest_q) begin
								largest_q <= acc_n;
							end
							acc_q   <= '0;
							fill_q  <= '0;
							phase_q <= 1'b0;
						end else begin
							acc_q  <= acc_n;
							fill_q <= fill_n;
						end
					end else if (!bit_in) begin
						zrl_q <= zrl_q + POS_W'(1);
					end else begin
						zrl_q   <= '0;
						acc_q   <= VAL_W'(1);
						fill_q  <= 3'd1;
						phase_q <= 1'b1;
					end
				end
				OP_CLOSE: begin
					if (phase_q) begin
						held_val_q   <= acc_q;
						held_len_q   <= fill_q;
						held_valid_q <= 1'b1;
						if (acc_q > largest_q) begin
							largest_q <= acc_q;
						end
						acc_q   <= '0;
						fill_q  <= '0;
						phase_q <= 1'b0;
					end
				end
				OP_FINAL: begin
					pos_q        <= '0;
					phase_q      <= 1'b0;
					zrl_q        <= '0;
					acc_q        <= '0;
					fill_q       <= '0;
					held_val_q   <= '0;
					held_len_q   <= '0;
					held_valid_q <= 1'b0;
					largest_q    <= '0;
					frags_q      <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			word_q <= exponent_word;
		end
		if (load_out) begin
			window_value   <= e_val;
			window_length  <= e_len;
			has_window     <= e_has;
			largest_window <= e_large;
			window_count   <= e_cnt;
			final_result   <= e_fin;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free)
		else $error("request loaded over an untaken result");

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (zrl_q == '0 && acc_q[0]))
		else $error("open window with pending zero run or even value");

	assert property (@(posedge clk) disable iff (!arst_n)
		!phase_q |-> (acc_q == '0 && fill_q == '0))
		else $error("window state left over outside a window");

	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 3'd7)
		else $error("window fill reached its limit without closing");

endmodule

// ===== src/clnw_exponent_recoder_core.sv =====
// Top level of the CLNW exponent recoder: controller plus scan datapath.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  in       | in_valid/in_stall   | exponent_word
//  out      | out_valid/out_stall | window_value, window_length, has_window,
//           |                     | largest_window, window_count, final_result
//  cfg      | cfg_we              | cfg_data (exponent_words)
//
// A word is handled in steps: a load, then the shared bit-scan step for each
// exponent bit, then an end check; an extra flush step is added when a held window
// and a zero run go out on the same bit, and a final request step at exponent end.
// Reset clears the scan state and sets the word count to 32.
// A stalled output request halts the scan at the next bit that makes a request.
module clnw_exponent_recoder_core #(
	parameter int unsigned WORD_BITS = clnw_pkg::WORD_BITS_DEF,
	parameter int unsigned MAX_WORDS = clnw_pkg::MAX_WORDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [clnw_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [WORD_BITS-1:0]        exponent_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [clnw_pkg::VAL_W-1:0]  window_value,
	output logic [clnw_pkg::LEN_W-1:0]  window_length,
	output logic                        has_window,
	output logic [clnw_pkg::VAL_W-1:0]  largest_window,
	output logic [clnw_pkg::LEN_W-1:0]  window_count,
	output logic                        final_result
);
	import clnw_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	clnw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	clnw_dp #(
		.WORD_BITS (WORD_BITS),
		.MAX_WORDS (MAX_WORDS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.exponent_word  (exponent_word),
		.cmd            (cmd),
		.sts            (sts),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.window_value   (window_value),
		.window_length  (window_length),
		.has_window     (has_window),
		.largest_window (largest_window),
		.window_count   (window_count),
		.final_result   (final_result)
	);

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the CLNW exponent recoder core.
`timescale 1ns / 1ps

typedef struct packed {
	logic [clnw_pkg::VAL_W-1:0] win_value;
	logic [clnw_pkg::LEN_W-1:0] win_length;
	logic                       carries;
	logic [clnw_pkg::VAL_W-1:0] largest;
	logic [clnw_pkg::LEN_W-1:0] total;
	logic                       is_final;
} recode_fragment_t;

// Recodes the accepted exponent words in the order taken and keeps the fragments it
// expects in order, so that results from the block can be matched one by one.
class recode_scoreboard;
	logic [clnw_pkg::CFG_W-1:0] words_setting;
	int unsigned bits_scanned, zero_run, win_bits, win_fill;
	int unsigned held_bits, held_len, largest_seen, emitted;
	bit in_window, held_live;
	int unsigned mismatches, fragments_checked, words_noted, exponents_done;
	recode_fragment_t expected_q[$];

	function new();
		words_setting = clnw_pkg::WORDS_RESET;
		restart();
	endfunction

	function void restart();
		bits_scanned = 0;
		zero_run = 0;
		win_bits = 0;
		win_fill = 0;
		held_bits = 0;
		held_len = 0;
		largest_seen = 0;
		emitted = 0;
		in_window = 0;
		held_live = 0;
	endfunction

	function void queue_fragment(input int unsigned v, input int unsigned l, input bit c,
			input int unsigned big, input int unsigned cnt, input bit fin);
		recode_fragment_t f;
		f.win_value = v[clnw_pkg::VAL_W-1:0];
		f.win_length = l[clnw_pkg::LEN_W-1:0];
		f.carries = c;
		f.largest = big[clnw_pkg::VAL_W-1:0];
		f.total = cnt[clnw_pkg::LEN_W-1:0];
		f.is_final = fin;
		expected_q.push_back(f);
	endfunction

	function void emit_fragment(input int unsigned v, input int unsigned l);
		emitted++;
		queue_fragment(v, l, 1'b1, 0, 0, 1'b0);
	endfunction

	function void flush_held();
		if (held_live) begin
			emit_fragment(held_bits, held_len);
			held_live = 0;
		end
	endfunction

	// The newest window is held back so that trailing zeros can still extend it.
	function void close_window();
		flush_held();
		held_bits = win_bits & 32'h7f;
		held_len = win_fill;
		held_live = 1;
		if (held_bits > largest_seen)
			largest_seen = held_bits;
		win_bits = 0;
		win_fill = 0;
		in_window = 0;
	endfunction

	function void note_word(input logic [clnw_pkg::WORD_BITS_DEF-1:0] w);
		int unsigned span, width, k;
		words_noted++;
		// A count of zero acts as one word, a count above the maximum as the maximum.
		if (words_setting == 0)
			span = 1;
		else if (words_setting > clnw_pkg::MAX_WORDS_DEF)
			span = clnw_pkg::MAX_WORDS_DEF;
		else
			span = words_setting;
		span = span * clnw_pkg::WORD_BITS_DEF;
		if (span < clnw_pkg::THRESH_W5)
			width = 4;
		else if (span < clnw_pkg::THRESH_W6)
			width = 5;
		else if (span < clnw_pkg::THRESH_W7)
			width = 6;
		else
			width = 7;
		for (k = 0; k < clnw_pkg::WORD_BITS_DEF; k++) begin
			if (in_window) begin
				if (w[k])
					win_bits = win_bits | (1 << (win_fill & 7));
				win_fill++;
				if (win_fill >= width)
					close_window();
			end else if (!w[k]) begin
				zero_run++;
			end else begin
				if (zero_run > 0) begin
					flush_held();
					emit_fragment(0, zero_run);
					zero_run = 0;
				end
				win_bits = 1;
				win_fill = 1;
				in_window = 1;
			end
			bits_scanned++;
		end
		if (bits_scanned >= span) begin
			if (in_window)
				close_window();
			if (held_live) begin
				emitted++;
				queue_fragment(held_bits, held_len + zero_run, 1'b1, largest_seen, emitted,
					1'b1);
			end else begin
				queue_fragment(0, 0, 1'b0, 0, 0, 1'b1);
			end
			exponents_done++;
			restart();
		end
	endfunction

	function void check(input recode_fragment_t got);
		recode_fragment_t want;
		if (expected_q.size() == 0) begin
			$error("fragment with none expected: window_value %0d window_length %0d",
				got.win_value, got.win_length);
			mismatches++;
			return;
		end
		want = expected_q.pop_front();
		fragments_checked++;
		if (got.win_value !== want.win_value) begin
			$error("window_value: expected %0d, got %0d", want.win_value, got.win_value);
			mismatches++;
		end
		if (got.win_length !== want.win_length) begin
			$error("window_length: expected %0d, got %0d", want.win_length, got.win_length);
			mismatches++;
		end
		if (got.carries !== want.carries) begin
			$error("has_window: expected %0d, got %0d", want.carries, got.carries);
			mismatches++;
		end
		if (got.largest !== want.largest) begin
			$error("largest_window: expected %0d, got %0d", want.largest, got.largest);
			mismatches++;
		end
		if (got.total !== want.total) begin
			$error("window_count: expected %0d, got %0d", want.total, got.total);
			mismatches++;
		end
		if (got.is_final !== want.is_final) begin
			$error("final_result: expected %0d, got %0d", want.is_final, got.is_final);
			mismatches++;
		end
	endfunction
endclass

module testbench;
	import clnw_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 2 * WORD_BITS_DEF + 16;
	localparam int unsigned CYCLE_LIMIT = 500000;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [CFG_W-1:0]            cfg_data;
	logic                        in_valid;
	logic                        in_stall;
	logic [WORD_BITS_DEF-1:0]    exponent_word;
	logic                        out_valid;
	logic                        out_stall;
	logic [VAL_W-1:0]            window_value;
	logic [LEN_W-1:0]            window_length;
	logic                        has_window;
	logic [VAL_W-1:0]            largest_window;
	logic [LEN_W-1:0]            window_count;
	logic                        final_result;

	recode_scoreboard sb;
	int unsigned send_gap_pct, stall_pct, cycles;

	clnw_exponent_recoder_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.exponent_word  (exponent_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.window_value   (window_value),
		.window_length  (window_length),
		.has_window     (has_window),
		.largest_window (largest_window),
		.window_count   (window_count),
		.final_result   (final_result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("[clnw_exponent_recoder_core] ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check('{window_value, window_length, has_window, largest_window,
				window_count, final_result});
	end

	// Every task below starts and ends just after a falling edge.
	task automatic send_word(input logic [WORD_BITS_DEF-1:0] w);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		exponent_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_word(w);
		@(negedge clk);
	endtask

	// A word can yield no fragment, so the scan may still run after the queue drains.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_words(input logic [CFG_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.words_setting = v;
	endtask

	task automatic set_idling(input int unsigned mode);
		case (mode % 3)
			0: begin
				send_gap_pct = 25;
				stall_pct = 74;
			end
			1: begin
				send_gap_pct = 74;
				stall_pct = 25;
			end
			default: begin
				send_gap_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	// Mixes sparse, dense and degenerate words so both zero runs and windows vary.
	function automatic logic [WORD_BITS_DEF-1:0] pick_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 32'd1 << $urandom_range(31);
			3, 4: return $urandom & $urandom & $urandom;
			5: return $urandom | $urandom;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_phase(input logic [CFG_W-1:0] words, input int unsigned n,
			input int unsigned mode, input int pause_at);
		write_words(words);
		set_idling(mode);
		for (int i = 0; i < n; i++) begin
			if (i == pause_at) begin
				in_valid <= 1'b0;
				while (sb.expected_q.size() != 0)
					@(negedge clk);
			end
			send_word(pick_word());
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		exponent_word = '0;
		out_stall = 1'b0;
		send_gap_pct = 0;
		stall_pct = 0;
		cycles = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Single-word exponents: zero, all ones, a window cut short by the top,
		// a lone low window stretched by trailing zeros, alternating bits and a mixed word.
		set_idling(0);
		write_words(8'd1);
		send_word(32'h0000_0000);
		send_word(32'hffff_ffff);
		send_word(32'h8000_0000);
		send_word(32'h0000_0001);
		send_word(32'h5555_5555);
		send_word(32'haaaa_aaaa);
		send_word(32'h1234_5678);

		// Shrinking the count mid-exponent ends it after the next word.
		write_words(8'd3);
		send_word(32'h0001_0000);
		send_word(32'h0000_0000);
		write_words(8'd1);
		send_word(32'h0000_0008);

		// A count of zero acts as one word.
		write_words(8'd0);
		send_word(32'h7fff_fffe);

		// Two-word exponents: all zero, a window across the word boundary,
		// a window followed by a whole zero word, and a high bit alone.
		write_words(8'd2);
		send_word(32'h0000_0000);
		send_word(32'h0000_0000);
		send_word(32'hc000_0000);
		send_word(32'h0000_0003);
		send_word(32'h0000_0010);
		send_word(32'h0000_0000);
		send_word(32'h0000_0000);
		send_word(32'h8000_0000);

		run_phase(8'd1, 30, 0, -1);
		run_phase(8'd3, 30, 0, -1);
		run_phase(8'd5, 30, 0, 17);
		run_phase(8'd8, 32, 1, -1);
		run_phase(8'd0, 15, 1, -1);
		run_phase(8'd24, 48, 1, -1);
		run_phase(8'd56, 56, 2, -1);

		// Above the maximum acts as the maximum: a single low one gives the
		// longest fragment the block can report.
		write_words(8'd255);
		set_idling(2);
		send_word(32'h0000_0001);
		for (int i = 1; i < MAX_WORDS_DEF; i++)
			send_word(32'h0000_0000);

		settle();
		$display("Recoded %0d exponents from %0d words at word counts 0 to 255 (windows 4 to 7 bits).",
			sb.exponents_done, sb.words_noted);
		$display("Checked %0d fragments, %0d mismatches.", sb.fragments_checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("[clnw_exponent_recoder_core] OK");
		else
			$display("[clnw_exponent_recoder_core] ERROR");
		$finish;
	end

endmodule
